/* design/macd_pkg.sv */
// Shared types, constants and register codes for the MACD indicator stream.
package macd_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int ALPHA_W          = 17;
  localparam int ALPHA_FRAC       = 16;
  localparam int COUNT_W          = 16;
  localparam int APB_ADDR_W       = 4;
  localparam int APB_DATA_W       = 32;
  localparam int EXTRA_FRAC_DEF   = 16;
  localparam int MUL_CHUNK_W      = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE         = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_SHORT_RESET = 17'd10082;
  localparam logic [ALPHA_W-1:0] ALPHA_LONG_RESET  = 17'd4855;
  localparam logic [ALPHA_W-1:0] ALPHA_SIG_RESET   = 17'd13107;
  localparam logic [COUNT_W-1:0] MIN_SAMPLES_RESET = 16'd35;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_ALPHA_SHORT,
    REG_ALPHA_LONG,
    REG_ALPHA_SIGNAL,
    REG_MIN_SAMPLES
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_MACD,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_SHORT,
    PH_LONG,
    PH_SIGNAL
  } phase_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_short;
    logic [ALPHA_W-1:0] alpha_long;
    logic [ALPHA_W-1:0] alpha_signal;
    logic [COUNT_W-1:0] min_samples;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       series_start;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] macd_value;
    logic signed [SAMPLE_W-1:0] signal_value;
    logic signed [SAMPLE_W-1:0] histogram;
    logic                       enough_samples;
  } result_t;

endpackage

/* design/macd_indicator_stream.sv */
// MACD indicator stream: sequencer, average state and output stage around a shared multiplier.
//
//   channel   direction  handshake                      payload
//   item      in         item_valid / item_ready        item_t   (sample, series_start)
//   result    out        result_valid / result_ready    result_t (macd, signal, histogram, flag)
//   config    in         APB psel/penable/pwrite/pready 4 registers at byte address 4*i
//
// A seeding beat goes from idle straight to the output state; any other beat runs
// the one 33x18 multiplier once per average, in NCH operand chunks, where
// NCH = ceil((33+EXTRA_FRACTION_BITS)/32).
// item_ready is high only in the idle state; the result register lets the next
// beat start while a result waits. Reset clears all averages and the sample count.
module macd_indicator_stream import macd_pkg::*; #(
  parameter int EXTRA_FRACTION_BITS = EXTRA_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = SAMPLE_W + EXTRA_FRACTION_BITS;
  localparam int DW = AW + 1;

  cfg_t                cfg;
  state_t              state;
  state_t              state_next;
  phase_t              phase;
  phase_t              phase_next;
  logic signed [AW-1:0] x_reg;
  logic signed [AW-1:0] x_in;
  logic signed [AW-1:0] short_avg;
  logic signed [AW-1:0] long_avg;
  logic signed [AW-1:0] signal_avg;
  logic signed [AW-1:0] macd_reg;
  logic [COUNT_W-1:0]   sample_count;
  logic                 accept;
  logic                 seed;
  logic                 out_load;
  logic                 mul_start;
  logic                 mul_done;
  logic signed [DW-1:0] mul_opnd;
  logic signed [DW-1:0] mul_scaled;
  logic [ALPHA_W-1:0]   mul_alpha;
  logic signed [AW-1:0] tgt_sel;
  logic signed [AW-1:0] avg_sel;
  logic signed [AW-1:0] avg_new;
  logic signed [DW-1:0] hist_full;

  function automatic logic signed [AW-1:0] acc_sat(input logic signed [DW-1:0] v);
    logic signed [AW-1:0] r;
    if (v[DW-1] == v[DW-2]) begin
      r = v[AW-1:0];
    end else begin
      r = {v[DW-1], {(AW-1){~v[DW-1]}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] out_sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0]       sh;
    logic [DW-SAMPLE_W:0]       hi;
    logic signed [SAMPLE_W-1:0] r;
    sh = v >>> EXTRA_FRACTION_BITS;
    hi = sh[DW-1:SAMPLE_W-1];
    if ((&hi) || !(|hi)) begin
      r = sh[SAMPLE_W-1:0];
    end else begin
      r = {sh[DW-1], {(SAMPLE_W-1){~sh[DW-1]}}};
    end
    return r;
  endfunction

  macd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  macd_mul #(
    .DATA_W  (DW),
    .CHUNK_W (MUL_CHUNK_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_opnd),
    .alpha   (mul_alpha),
    .done    (mul_done),
    .scaled  (mul_scaled)
  );

  assign x_in   = AW'(item.sample) <<< EXTRA_FRACTION_BITS;
  assign accept = item_valid && item_ready;
  assign seed   = item.series_start || (sample_count == '0);

  always_comb begin
    case (phase)
      PH_SHORT: begin
        avg_sel   = short_avg;
        tgt_sel   = x_reg;
        mul_alpha = cfg.alpha_short;
      end
      PH_LONG: begin
        avg_sel   = long_avg;
        tgt_sel   = x_reg;
        mul_alpha = cfg.alpha_long;
      end
      default: begin
        avg_sel   = signal_avg;
        tgt_sel   = macd_reg;
        mul_alpha = cfg.alpha_signal;
      end
    endcase
  end

  assign mul_opnd  = DW'(tgt_sel) - DW'(avg_sel);
  assign avg_new   = AW'(DW'(avg_sel) + mul_scaled);
  assign hist_full = DW'(macd_reg) - DW'(signal_avg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_SHORT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    item_ready = 1'b0;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          phase_next = PH_SHORT;
          state_next = seed ? ST_FINISH : ST_LOAD;
        end
      end
      ST_LOAD: begin
        mul_start  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          unique case (phase)
            PH_SHORT: begin
              phase_next = PH_LONG;
              state_next = ST_LOAD;
            end
            PH_LONG:  state_next = ST_MACD;
            default:  state_next = ST_FINISH;
          endcase
        end
      end
      ST_MACD: begin
        phase_next = PH_SIGNAL;
        state_next = ST_LOAD;
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_avg    <= '0;
      long_avg     <= '0;
      signal_avg   <= '0;
      macd_reg     <= '0;
      sample_count <= '0;
    end else begin
      if (accept && seed) begin
        short_avg    <= x_in;
        long_avg     <= x_in;
        signal_avg   <= '0;
        macd_reg     <= '0;
        sample_count <= COUNT_W'(1);
      end
      if (state == ST_MUL && mul_done) begin
        case (phase)
          PH_SHORT: short_avg <= avg_new;
          PH_LONG:  long_avg  <= avg_new;
          default: begin
            signal_avg <= avg_new;
            if (sample_count != COUNT_MAX) begin
              sample_count <= sample_count + 1'b1;
            end
          end
        endcase
      end
      if (state == ST_MACD) begin
        macd_reg <= acc_sat(DW'(short_avg) - DW'(long_avg));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg <= x_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.macd_value     <= out_sat(DW'(macd_reg));
      result.signal_value   <= out_sat(DW'(signal_avg));
      result.histogram      <= out_sat(hist_full);
      result.enough_samples <= (sample_count >= cfg.min_samples);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_after_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> sample_count != '0)
    else $error("sample count zero after a beat");

  a_seed_state: assert property (@(posedge clk) disable iff (rst)
    (accept && seed) |=> (short_avg == long_avg) && (signal_avg == '0) && (macd_reg == '0))
    else $error("seeding left averages inconsistent");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && result_valid && !result_ready) |=> state == ST_FINISH)
    else $error("result overwritten while waiting");

  a_idle_after_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result_valid && state == ST_IDLE)
    else $error("result load did not return to idle");
`endif

endmodule

/* design/macd_cfg_regs.sv */
// APB register file holding the three average weights and the sample threshold.
module macd_cfg_regs import macd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t         index;
  logic               wr_en;
  logic [ALPHA_W-1:0] alpha_raw;
  logic [ALPHA_W-1:0] alpha_clamped;

  assign index         = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en         = psel && penable && pwrite;
  assign pready        = 1'b1;
  assign alpha_raw     = pwdata[ALPHA_W-1:0];
  assign alpha_clamped = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_short  <= ALPHA_SHORT_RESET;
      cfg.alpha_long   <= ALPHA_LONG_RESET;
      cfg.alpha_signal <= ALPHA_SIG_RESET;
      cfg.min_samples  <= MIN_SAMPLES_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_ALPHA_SHORT:  cfg.alpha_short  <= alpha_clamped;
        REG_ALPHA_LONG:   cfg.alpha_long   <= alpha_clamped;
        REG_ALPHA_SIGNAL: cfg.alpha_signal <= alpha_clamped;
        REG_MIN_SAMPLES:  cfg.min_samples  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_ALPHA_SHORT:  prdata = APB_DATA_W'(cfg.alpha_short);
      REG_ALPHA_LONG:   prdata = APB_DATA_W'(cfg.alpha_long);
      REG_ALPHA_SIGNAL: prdata = APB_DATA_W'(cfg.alpha_signal);
      REG_MIN_SAMPLES:  prdata = APB_DATA_W'(cfg.min_samples);
      default:          prdata = '0;
    endcase
  end

endmodule

/* design/macd_mul.sv */
// Shared multiplier: floor(operand * alpha / 2^16), one operand chunk per cycle.
module macd_mul import macd_pkg::*; #(
  parameter int DATA_W  = SAMPLE_W + EXTRA_FRAC_DEF + 1,
  parameter int CHUNK_W = MUL_CHUNK_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] operand,
  input  logic [ALPHA_W-1:0]       alpha,
  output logic                     done,
  output logic signed [DATA_W-1:0] scaled
);

  localparam int NCH    = (DATA_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = NCH * CHUNK_W;
  localparam int PROD_W = CHUNK_W + ALPHA_W + 2;
  localparam int ACC_W  = PAD_W + ALPHA_W + 2;
  localparam int CNT_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NCH - 1);

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [PAD_W-1:0]         opnd_sh;
  logic signed [ACC_W-1:0]  acc;
  logic [CHUNK_W-1:0]       chunk;
  logic signed [CHUNK_W:0]  mul_a;
  logic signed [ALPHA_W:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  assign chunk  = opnd_sh[PAD_W-1 -: CHUNK_W];
  assign mul_a  = {(cnt == '0) ? chunk[CHUNK_W-1] : 1'b0, chunk};
  assign mul_b  = {1'b0, alpha};
  assign prod   = mul_a * mul_b;
  assign scaled = acc[ALPHA_FRAC +: DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd_sh <= PAD_W'(operand);
      acc     <= '0;
    end else if (busy) begin
      opnd_sh <= opnd_sh << CHUNK_W;
      acc     <= (acc <<< CHUNK_W) + ACC_W'(prod);
    end
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for macd_indicator_stream: predicts MACD, signal and histogram per sample.
module tb_top;
  import macd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_SAMPLES = 222;
  localparam int EXTRA_FRAC = EXTRA_FRAC_DEF;
  localparam int ACC_W = SAMPLE_W + EXTRA_FRAC;

  class macd_scoreboard;
    cfg_t regs;
    longint short_avg;
    longint long_avg;
    longint signal_avg;
    int unsigned sample_cnt;
    result_t expected_q[$];
    int mismatches;
    int checked;
    int noted;

    function new();
      regs.alpha_short = ALPHA_SHORT_RESET;
      regs.alpha_long = ALPHA_LONG_RESET;
      regs.alpha_signal = ALPHA_SIG_RESET;
      regs.min_samples = MIN_SAMPLES_RESET;
      short_avg = 0;
      long_avg = 0;
      signal_avg = 0;
      sample_cnt = 0;
      mismatches = 0;
      checked = 0;
      noted = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
      logic [ALPHA_W-1:0] w;
      w = value[ALPHA_W-1:0];
      if (w > ALPHA_ONE) w = ALPHA_ONE;
      case (idx)
        REG_ALPHA_SHORT: regs.alpha_short = w;
        REG_ALPHA_LONG: regs.alpha_long = w;
        REG_ALPHA_SIGNAL: regs.alpha_signal = w;
        REG_MIN_SAMPLES: regs.min_samples = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // avg + floor(w * (x - avg) / 2^16), kept wide enough for the full product
    function longint ema_step(longint avg, longint x, logic [ALPHA_W-1:0] w);
      logic signed [95:0] prod;
      logic signed [95:0] wt;
      prod = x - avg;
      wt = $signed({79'd0, w});
      prod = (prod * wt) >>> ALPHA_FRAC;
      return avg + longint'(prod);
    endfunction

    function logic [SAMPLE_W-1:0] to_q16(longint v);
      longint s;
      s = clamp(v >>> EXTRA_FRAC, SAMPLE_W);
      return s[SAMPLE_W-1:0];
    endfunction

    function void note_sample(item_t it);
      longint x;
      longint macd;
      result_t r;
      x = longint'(it.sample) <<< EXTRA_FRAC;
      if (it.series_start || sample_cnt == 0) begin
        short_avg = x;
        long_avg = x;
        signal_avg = 0;
        sample_cnt = 1;
      end else begin
        short_avg = ema_step(short_avg, x, regs.alpha_short);
        long_avg = ema_step(long_avg, x, regs.alpha_long);
        macd = clamp(short_avg - long_avg, ACC_W);
        signal_avg = ema_step(signal_avg, macd, regs.alpha_signal);
        if (sample_cnt < COUNT_MAX) sample_cnt++;
      end
      macd = clamp(short_avg - long_avg, ACC_W);
      r.macd_value = to_q16(macd);
      r.signal_value = to_q16(signal_avg);
      r.histogram = to_q16(macd - signal_avg);
      r.enough_samples = (sample_cnt >= regs.min_samples);
      expected_q = {expected_q, r};
      noted++;
    endfunction

    task report(string what, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
      mismatches++;
      if (mismatches <= 30)
        $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result with no sample pending", got.macd_value, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.macd_value !== want.macd_value)
        report("macd_value", got.macd_value, want.macd_value);
      if (got.signal_value !== want.signal_value)
        report("signal_value", got.signal_value, want.signal_value);
      if (got.histogram !== want.histogram)
        report("histogram", got.histogram, want.histogram);
      if (got.enough_samples !== want.enough_samples)
        report("enough_samples", 32'(got.enough_samples), 32'(want.enough_samples));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  macd_scoreboard sb;
  int cycles;
  int sent;
  int settings;
  int holds;
  bit steady;
  bit hold_req;
  int price;

  macd_indicator_stream u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int idle_cycles();
    if (steady) return 0;
    return $urandom_range(0, 6);
  endfunction

  task apb_write(reg_index_t idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task set_weights(logic [APB_DATA_W-1:0] a_short, logic [APB_DATA_W-1:0] a_long,
                   logic [APB_DATA_W-1:0] a_signal, logic [APB_DATA_W-1:0] min_cnt);
    apb_write(REG_ALPHA_SHORT, a_short);
    apb_write(REG_ALPHA_LONG, a_long);
    apb_write(REG_ALPHA_SIGNAL, a_signal);
    apb_write(REG_MIN_SAMPLES, min_cnt);
    settings++;
  endtask

  task send_sample(logic signed [SAMPLE_W-1:0] s, logic start);
    int gap;
    item_t it;
    it.sample = s;
    it.series_start = start;
    steady = ((sent / 50) % 4 == 3);
    gap = idle_cycles();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_ready !== 1'b1);
    sb.note_sample(it);
    sent++;
  endtask

  task send_random();
    int r;
    logic start;
    logic signed [SAMPLE_W-1:0] s;
    r = $urandom_range(0, 99);
    start = ($urandom_range(0, 99) < 4);
    if (start) price = $signed($urandom) >>> 3;
    if (r < 70) begin
      price += $urandom_range(0, 1 << 20) - (1 << 19);
      s = price;
    end else if (r < 90) begin
      s = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: s = 32'sh7FFF_FFFF;
        1: s = 32'sh8000_0000;
        2: s = 32'sh0000_0000;
        default: s = -32'sd1;
      endcase
    end
    send_sample(s, start);
  endtask

  // drop valid after the last beat and hold until every result is back
  task drain();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    result_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
        holds++;
      end else begin
        stall = idle_cycles();
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (result_valid !== 1'b1);
      sb.check_result(result);
    end
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    price = 32'h0064_0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset weights; first beat seeds from an empty count
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh0000_0000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sh0001_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b0);
    drain();

    // short follows the sample, long stays at the seed: drive the outputs into saturation
    set_weights(32'h0001_FFFF, 32'h0, 32'h0001_0000, 32'h0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0000, 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_weights(32'd10082, 32'd4855, 32'd13107, 32'd35);
        1: set_weights(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
        2: set_weights(32'h0, 32'h0001_0000, 32'h0, 32'h0000_FFFF);
        3: set_weights($urandom_range(0, 65536), $urandom_range(0, 65536),
                       $urandom_range(0, 65536), 32'd1);
        4: set_weights($urandom_range(0, 65536), $urandom_range(0, 65536),
                       $urandom_range(0, 65536), $urandom_range(2, 40));
        default: set_weights({15'($urandom), 17'h1FFFF}, {15'($urandom), 17'h1FFFF},
                             {15'($urandom), 17'h1FFFF}, {16'($urandom), 16'd3});
      endcase
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if ((p == 0 || p == 3) && i == 40) hold_req = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d samples and %0d checked results under %0d register settings,",
             sent, sb.checked, settings + 1);
    $display("with %0d output hold-offs of %0d cycles and %0d mismatches",
             holds, HOLD_CYCLES, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/macd_pkg.sv
design/macd_cfg_regs.sv
design/macd_mul.sv
design/macd_indicator_stream.sv
sim/tb_top.sv
